// ----- hdl/rom_region_checksum_diagnostic_core_defines.svh -----
// Assertion macros shared by the checksum diagnostic RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ROM_REGION_CHECKSUM_DIAGNOSTIC_CORE_DEFINES_SVH
`define ROM_REGION_CHECKSUM_DIAGNOSTIC_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RRCD_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrcd: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RRCD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrcd: next-cycle check failed");

`endif

// ----- hdl/rrcd_pkg.sv -----
// ----------------------------------------------------------------------------
// rrcd_pkg
// Request and result types and command codes of the ROM checksum diagnostic.
// ----------------------------------------------------------------------------
`default_nettype none

package rrcd_pkg;

    // Command codes carried in the request selector
    localparam logic [1:0] CMD_WORD    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // One input request, as held in the input register
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] rom_word;
        logic        region_last;
        logic [15:0] stored_sum;
        logic        ignition_on;
    } rrcd_item_t;

    // Result flags, last field in the lowest bit
    typedef struct packed {
        logic test_failed;
        logic test_complete;
        logic cal_fail;
        logic cal_done;
        logic app_fail;
        logic app_done;
    } rrcd_flags_t;

endpackage

`default_nettype wire

// ----- hdl/rrcd_engine.sv -----
// ----------------------------------------------------------------------------
// rrcd_engine
// Region sums, pass/fail flags and report latch; updates once per request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rom_region_checksum_diagnostic_core_defines.svh"

module rrcd_engine #(
    parameter int SUM_WIDTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire rrcd_pkg::rrcd_item_t item,
    output rrcd_pkg::rrcd_flags_t    flags_next
);

    logic [SUM_WIDTH-1:0]  app_accum_reg, app_accum_next;
    logic [SUM_WIDTH-1:0]  cal_accum_reg, cal_accum_next;
    logic                  app_finished_reg, app_finished_next;
    logic                  app_bad_reg, app_bad_next;
    logic                  cal_finished_reg, cal_finished_next;
    logic                  cal_bad_reg, cal_bad_next;
    logic                  reported_reg, reported_next;
    logic                  failed_reg, failed_next;

    logic [SUM_WIDTH+15:0] word_wide;
    logic [SUM_WIDTH+15:0] stored_wide;
    logic [SUM_WIDTH-1:0]  word_ext;
    logic [SUM_WIDTH-1:0]  stored_ext;
    logic [SUM_WIDTH-1:0]  app_sum;
    logic [SUM_WIDTH-1:0]  app_rest;
    logic [SUM_WIDTH-1:0]  cal_sum;
    logic                  do_report;
    logic                  restart;

    // Reduce the 16-bit fields to the sum width
    assign word_wide   = {{SUM_WIDTH{1'b0}}, item.rom_word};
    assign stored_wide = {{SUM_WIDTH{1'b0}}, item.stored_sum};
    assign word_ext    = word_wide[SUM_WIDTH-1:0];
    assign stored_ext  = stored_wide[SUM_WIDTH-1:0];

    // Wrapping adds for both regions and the application check term
    assign app_sum  = app_accum_reg + word_ext;
    assign app_rest = app_sum - stored_ext;
    assign cal_sum  = cal_accum_reg + word_ext;

    assign restart = advance && (item.cmd == rrcd_pkg::CMD_RESTART);

    // Decode the command, then run the report step on the updated flags
    always_comb
    begin
        app_accum_next    = app_accum_reg;
        cal_accum_next    = cal_accum_reg;
        app_finished_next = app_finished_reg;
        app_bad_next      = app_bad_reg;
        cal_finished_next = cal_finished_reg;
        cal_bad_next      = cal_bad_reg;
        reported_next     = reported_reg;
        failed_next       = failed_reg;
        do_report         = 1'b0;

        unique case (item.cmd)
            rrcd_pkg::CMD_WORD:
            begin
                if (!app_finished_reg)
                begin
                    app_accum_next = app_sum;
                    if (item.region_last)
                    begin
                        app_finished_next = 1'b1;
                        app_bad_next      = (app_rest != stored_ext);
                    end
                end
                else if (!cal_finished_reg)
                begin
                    cal_accum_next = cal_sum;
                    if (item.region_last)
                    begin
                        cal_finished_next = 1'b1;
                        cal_bad_next      = (cal_sum != '0);
                    end
                end
                do_report = 1'b1;
            end
            rrcd_pkg::CMD_TICK:
            begin
                do_report = 1'b1;
            end
            rrcd_pkg::CMD_RESTART:
            begin
                app_accum_next    = '0;
                cal_accum_next    = '0;
                app_finished_next = 1'b0;
                app_bad_next      = 1'b0;
                cal_finished_next = 1'b0;
                cal_bad_next      = 1'b0;
                reported_next     = 1'b0;
            end
            default:
            begin
                do_report = 1'b0;
            end
        endcase

        // Latch the overall result once, while ignition is on
        if (do_report && !reported_reg && item.ignition_on)
        begin
            if ((app_finished_next && app_bad_next) || (cal_finished_next && cal_bad_next))
            begin
                failed_next   = 1'b1;
                reported_next = 1'b1;
            end
            else
            begin
                reported_next = app_finished_next && cal_finished_next;
                if (app_finished_next && cal_finished_next)
                begin
                    failed_next = 1'b0;
                end
            end
        end
    end

    // Advance the state only when the request moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            app_accum_reg    <= '0;
            cal_accum_reg    <= '0;
            app_finished_reg <= 1'b0;
            app_bad_reg      <= 1'b0;
            cal_finished_reg <= 1'b0;
            cal_bad_reg      <= 1'b0;
            reported_reg     <= 1'b0;
            failed_reg       <= 1'b0;
        end
        else if (advance)
        begin
            app_accum_reg    <= app_accum_next;
            cal_accum_reg    <= cal_accum_next;
            app_finished_reg <= app_finished_next;
            app_bad_reg      <= app_bad_next;
            cal_finished_reg <= cal_finished_next;
            cal_bad_reg      <= cal_bad_next;
            reported_reg     <= reported_next;
            failed_reg       <= failed_next;
        end
    end

    // Result seen after this request's update
    assign flags_next.app_done      = app_finished_next;
    assign flags_next.app_fail      = app_bad_next;
    assign flags_next.cal_done      = cal_finished_next;
    assign flags_next.cal_fail      = cal_bad_next;
    assign flags_next.test_complete = reported_next;
    assign flags_next.test_failed   = failed_next;

    // The calibration region can only finish after the application region
    `RRCD_ASSERT_IMPLIES(a_cal_after_app, cal_finished_reg, app_finished_reg)
    // Restart never touches the non-volatile fail flag
    `RRCD_ASSERT_NEXT(a_restart_keeps_fail, restart, failed_reg == $past(failed_reg))
    // Once reported, the result stays reported until a restart
    `RRCD_ASSERT_NEXT(a_report_sticky, reported_reg && !restart, reported_reg)
    // No state moves while no request advances
    `RRCD_ASSERT_NEXT(a_hold_when_idle, !advance,
        $stable(app_accum_reg) && $stable(cal_accum_reg) && $stable(failed_reg))

endmodule

`default_nettype wire

// ----- hdl/rom_region_checksum_diagnostic_core.sv -----
// ----------------------------------------------------------------------------
// rom_region_checksum_diagnostic_core
// Additive word checksum over an application and a calibration ROM region.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: a ROM word, a report tick or a
//   restart, selected by s_axis_tuser. s_axis_tlast marks the last word of
//   a region; that word carries the region's stored checksum. Words of the
//   application region come first, then those of the calibration region.
//   Every request yields exactly one result on m_axis: the region done/fail
//   flags and the overall complete/failed flags after that request.
//   An accepted request loads the input register, then moves on to the
//   result register, which drives m_axis_tvalid, once that register is free.
//   Throughput is one request per cycle while the receiver keeps up; the
//   limit is the combinational sum and compare feeding the state registers.
//   When the receiver stalls the result register holds, the input register
//   still takes one more request, and s_axis_tready then drops until the
//   result is taken.
//   Reset clears both sums and all flags, including the failed flag.
//   A restart request clears everything except the failed flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rom_region_checksum_diagnostic_core #(
    parameter int SUM_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] rom_word, [31:16] stored_sum, [32] ignition_on, [39:33] zero
    input  wire logic [39:0] s_axis_tdata,
    // [1:0] cmd
    input  wire logic [1:0]  s_axis_tuser,
    // region_last
    input  wire logic        s_axis_tlast,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] app_done, [1] app_fail, [2] cal_done, [3] cal_fail,
    // [4] test_complete, [5] test_failed, [7:6] zero
    output logic [7:0]       m_axis_tdata
);

    logic                  in_valid_reg;
    rrcd_pkg::rrcd_item_t  in_item_reg;
    logic                  out_valid_reg;
    rrcd_pkg::rrcd_flags_t out_flags_reg;
    rrcd_pkg::rrcd_flags_t flags_next;

    logic out_free;
    logic advance;
    logic accept;

    // Handshake: the result register frees the input register
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.cmd         <= s_axis_tuser;
            in_item_reg.rom_word    <= s_axis_tdata[15:0];
            in_item_reg.region_last <= s_axis_tlast;
            in_item_reg.stored_sum  <= s_axis_tdata[31:16];
            in_item_reg.ignition_on <= s_axis_tdata[32];
        end
    end

    rrcd_engine #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (in_item_reg),
        .flags_next (flags_next)
    );

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_flags_reg <= flags_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_flags_reg};

endmodule

`default_nettype wire

// ----- test/rom_region_checksum_diagnostic_core_tb.sv -----
// ----------------------------------------------------------------------------
// rom_region_checksum_diagnostic_core_tb
// Drives ROM words, report ticks and restarts into the checksum diagnostic,
// predicts the flags after every request and checks each result in order.
// A directed opening covers the field extremes and the corner cases, then
// random sessions of well-formed application and calibration regions are
// mixed with noise, under random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------

module rom_region_checksum_diagnostic_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SUM_W          = 16;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam int          RANDOM_ITEMS   = 950;
    localparam int          QUIET_ITEMS    = 100;
    localparam int          LONG_HOLD      = 400;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          TAIL_CYCLES    = 10;

    // Predicts the diagnostic flags and keeps the flags still owed by the block
    class checksum_scoreboard;
        logic [SUM_W-1:0]      app_sum;
        logic [SUM_W-1:0]      cal_sum;
        bit                    app_finished;
        bit                    app_bad;
        bit                    cal_finished;
        bit                    cal_bad;
        bit                    reported;
        bit                    failed_latch;
        rrcd_pkg::rrcd_flags_t expected_flags[$];
        int                    errors;

        function new();
            clear_session();
            failed_latch = 1'b0;
            errors       = 0;
        endfunction

        // Drop everything but the non-volatile failed flag
        function void clear_session();
            app_sum      = '0;
            cal_sum      = '0;
            app_finished = 1'b0;
            app_bad      = 1'b0;
            cal_finished = 1'b0;
            cal_bad      = 1'b0;
            reported     = 1'b0;
        endfunction

        // Latch the overall result once, while ignition is on
        function void run_report(bit ign);
            if (reported || !ign)
                return;
            if ((app_finished && app_bad) || (cal_finished && cal_bad)) begin
                failed_latch = 1'b1;
                reported     = 1'b1;
            end else begin
                reported = app_finished && cal_finished;
                if (reported)
                    failed_latch = 1'b0;
            end
        endfunction

        function void note_request(rrcd_pkg::rrcd_item_t req);
            rrcd_pkg::rrcd_flags_t flags;
            logic [SUM_W-1:0]      rest;
            case (req.cmd)
                rrcd_pkg::CMD_WORD: begin
                    if (!app_finished) begin
                        app_sum = app_sum + req.rom_word[SUM_W-1:0];
                        if (req.region_last) begin
                            rest         = app_sum - req.stored_sum[SUM_W-1:0];
                            app_finished = 1'b1;
                            app_bad      = (rest != req.stored_sum[SUM_W-1:0]);
                        end
                    end else if (!cal_finished) begin
                        cal_sum = cal_sum + req.rom_word[SUM_W-1:0];
                        if (req.region_last) begin
                            cal_finished = 1'b1;
                            cal_bad      = (cal_sum != '0);
                        end
                    end
                    run_report(req.ignition_on);
                end
                rrcd_pkg::CMD_TICK:    run_report(req.ignition_on);
                rrcd_pkg::CMD_RESTART: clear_session();
                default:               ;
            endcase
            flags.app_done      = app_finished;
            flags.app_fail      = app_bad;
            flags.cal_done      = cal_finished;
            flags.cal_fail      = cal_bad;
            flags.test_complete = reported;
            flags.test_failed   = failed_latch;
            expected_flags.push_back(flags);
        endfunction

        function void check_flags(logic [7:0] data);
            rrcd_pkg::rrcd_flags_t exp_flags;
            string                 field_names[6];
            field_names = '{"app_done", "app_fail", "cal_done", "cal_fail",
                            "test_complete", "test_failed"};
            if (expected_flags.size() == 0) begin
                $error("result with nothing expected: tdata %h", data);
                errors++;
                return;
            end
            exp_flags = expected_flags.pop_front();
            for (int i = 0; i < 6; i++) begin
                if (data[i] !== exp_flags[i]) begin
                    $error("%s: expected %0b, actual %0b", field_names[i], exp_flags[i], data[i]);
                    errors++;
                end
            end
            if (data[7:6] !== 2'b00) begin
                $error("padding: expected 0, actual %0b", data[7:6]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    checksum_scoreboard sb;
    int                 sent_count;
    int                 sender_idle_pct;
    bit                 quiet;
    bit                 hold_off_request;
    int                 idle_cycles;

    rom_region_checksum_diagnostic_core #(
        .SUM_WIDTH(SUM_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Check every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_flags(m_axis_tdata);
    end

    // End the run when neither side moves for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver: random ready bursts, random stalls and one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (hold_off_request) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_off_request = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge clk);
            end
        end
    end

    function automatic bit pick_ignition();
        return $urandom_range(0, 4) != 0;
    endfunction

    // Offer one request from a falling edge and hold it until accepted
    task automatic send_request(logic [1:0] cmd, logic [15:0] word, bit last,
                                logic [15:0] stored, bit ign);
        rrcd_pkg::rrcd_item_t req;
        req.cmd         = cmd;
        req.rom_word    = word;
        req.region_last = last;
        req.stored_sum  = stored;
        req.ignition_on = ign;
        if (!quiet && $urandom_range(1, 100) <= sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {7'd0, ign, stored, word};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(req);
        sent_count++;
        @(negedge clk);
    endtask

    // Withdraw the request and hold until every result has come back
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.expected_flags.size() != 0);
    endtask

    // One region of ROM words; make_ok picks a last word and checksum that pass
    task automatic send_region(bit app_side, int n_words, bit make_ok);
        logic [15:0] region_sum;
        logic [15:0] word;
        logic [15:0] stored;
        logic [15:0] total;
        region_sum = '0;
        for (int i = 0; i < n_words; i++) begin
            word   = 16'($urandom);
            stored = 16'($urandom);
            if (i == n_words - 1 && make_ok) begin
                if (app_side) begin
                    // keep the total even so that twice the stored value matches it
                    word[0] = region_sum[0];
                    total   = region_sum + word;
                    stored  = {1'($urandom_range(0, 1)), total[15:1]};
                end else begin
                    word = 16'd0 - region_sum;
                end
            end
            if (i != n_words - 1 && $urandom_range(0, 9) == 0)
                send_request(rrcd_pkg::CMD_TICK, 16'($urandom),
                             1'($urandom_range(0, 1)), 16'($urandom), pick_ignition());
            send_request(rrcd_pkg::CMD_WORD, word, i == n_words - 1, stored,
                         pick_ignition());
            region_sum = region_sum + word;
        end
    endtask

    // Optional restart, application region, calibration region, then a few reports
    task automatic run_session();
        int n_app;
        int n_cal;
        if ($urandom_range(0, 3) != 0)
            send_request(rrcd_pkg::CMD_RESTART, 16'($urandom), 1'($urandom_range(0, 1)),
                         16'($urandom), 1'($urandom_range(0, 1)));
        n_app = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        n_cal = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        send_region(1'b1, n_app, $urandom_range(0, 2) != 0);
        send_region(1'b0, n_cal, $urandom_range(0, 2) != 0);
        repeat ($urandom_range(0, 3))
            send_request(rrcd_pkg::CMD_TICK, 16'($urandom), 1'($urandom_range(0, 1)),
                         16'($urandom), pick_ignition());
        if ($urandom_range(0, 4) == 0)
            send_request(rrcd_pkg::CMD_WORD, 16'($urandom), 1'($urandom_range(0, 1)),
                         16'($urandom), pick_ignition());
    endtask

    initial
    begin
        bit hold_done;
        bit drain_done;
        int random_end;
        sb               = new();
        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = rrcd_pkg::CMD_WORD;
        s_axis_tlast     = 1'b0;
        sent_count       = 0;
        sender_idle_pct  = 20;
        quiet            = 1'b0;
        hold_off_request = 1'b0;
        idle_cycles      = 0;
        hold_done        = 1'b0;
        drain_done       = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, ignition off, late words, unused command, restarts
        send_request(rrcd_pkg::CMD_TICK,    16'h0000, 1'b0, 16'h0000, 1'b1);
        send_request(rrcd_pkg::CMD_WORD,    16'hFFFF, 1'b0, 16'h0000, 1'b0);
        send_request(rrcd_pkg::CMD_WORD,    16'h0001, 1'b1, 16'h0000, 1'b0);
        send_request(rrcd_pkg::CMD_TICK,    16'hFFFF, 1'b1, 16'hFFFF, 1'b0);
        send_request(rrcd_pkg::CMD_WORD,    16'hFFFF, 1'b0, 16'h0000, 1'b1);
        send_request(rrcd_pkg::CMD_WORD,    16'h0001, 1'b1, 16'hFFFF, 1'b1);
        send_request(rrcd_pkg::CMD_WORD,    16'h1234, 1'b1, 16'h5678, 1'b1);
        send_request(CMD_UNUSED,            16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
        send_request(rrcd_pkg::CMD_RESTART, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
        send_request(rrcd_pkg::CMD_WORD,    16'h8000, 1'b1, 16'hFFFF, 1'b1);
        send_request(rrcd_pkg::CMD_RESTART, 16'h0000, 1'b0, 16'h0000, 1'b0);
        send_request(rrcd_pkg::CMD_TICK,    16'h0000, 1'b0, 16'h0000, 1'b1);
        send_request(rrcd_pkg::CMD_WORD,    16'h0002, 1'b1, 16'h0001, 1'b0);
        send_request(rrcd_pkg::CMD_WORD,    16'h0005, 1'b1, 16'h0000, 1'b1);
        send_request(CMD_UNUSED,            16'h0000, 1'b0, 16'h0000, 1'b0);
        send_request(rrcd_pkg::CMD_RESTART, 16'h0000, 1'b0, 16'h0000, 1'b1);
        send_request(rrcd_pkg::CMD_WORD,    16'h0000, 1'b1, 16'h0000, 1'b1);
        send_request(rrcd_pkg::CMD_WORD,    16'h0000, 1'b1, 16'hFFFF, 1'b1);
        send_request(rrcd_pkg::CMD_TICK,    16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
        send_request(rrcd_pkg::CMD_WORD,    16'hFFFF, 1'b0, 16'hFFFF, 1'b0);
        pause_until_drained();

        // Random: mostly well-formed sessions, some noise
        random_end = sent_count + RANDOM_ITEMS;
        while (sent_count < random_end) begin
            if (!hold_done && sent_count > random_end - 650) begin
                hold_off_request = 1'b1;
                hold_done        = 1'b1;
            end
            if (!drain_done && sent_count > random_end - 350) begin
                pause_until_drained();
                drain_done = 1'b1;
            end
            if (sent_count > random_end - QUIET_ITEMS)
                quiet = 1'b1;
            case ($urandom_range(0, 2))
                0:       sender_idle_pct = 0;
                1:       sender_idle_pct = 10;
                default: sender_idle_pct = 35;
            endcase
            if ($urandom_range(0, 3) != 0)
                run_session();
            else
                repeat ($urandom_range(1, 5))
                    send_request(2'($urandom_range(0, 3)), 16'($urandom),
                                 1'($urandom_range(0, 1)), 16'($urandom),
                                 1'($urandom_range(0, 1)));
        end

        // Drain and let the pipeline settle
        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_flags.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
